// ===== hw/rtl/digit_entry_seven_segment_scanner_core_macros.svh =====
// Assertion macros shared by the scanner RTL.
`ifndef DIGIT_ENTRY_SEVEN_SEGMENT_SCANNER_CORE_MACROS_SVH
`define DIGIT_ENTRY_SEVEN_SEGMENT_SCANNER_CORE_MACROS_SVH

// Checked on clk, held off while in reset.
`define DESS_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Checked on clk at every edge, reset included.
`define DESS_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hw/rtl/dess_pkg.sv =====
// Package: constants, types and decode functions of the digit entry scanner.
package dess_pkg;

	localparam int NUM_DIGITS = 6;
	localparam int IDX_W      = (NUM_DIGITS > 1) ? $clog2(NUM_DIGITS) : 1;
	localparam int CHAR_W     = 8;
	localparam int DIGIT_W    = 4;
	localparam int SEG_W      = 7;

	localparam logic [CHAR_W-1:0] CHAR_ZERO = 8'h30;
	localparam logic [CHAR_W-1:0] CHAR_NINE = 8'h39;

	localparam logic [SEG_W-1:0] SEG_LUT [16] = '{
		7'h3F, 7'h06, 7'h5B, 7'h4F, 7'h66, 7'h6D, 7'h7D, 7'h07,
		7'h7F, 7'h6F, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00
	};

	typedef logic [IDX_W-1:0] idx_t;

	typedef struct packed {
		logic               shift;
		logic [DIGIT_W-1:0] digit;
	} dess_push_t;

	typedef struct packed {
		logic [NUM_DIGITS-1:0][DIGIT_W-1:0] slots;
		logic [NUM_DIGITS-1:0]              filled;
	} dess_buf_t;

	function automatic logic [SEG_W-1:0] select_for(input idx_t idx);
		logic [SEG_W-1:0] pat;
		pat = '1;
		if (int'(idx) + 1 < SEG_W) begin
			pat = ~(SEG_W'(1) << (int'(idx) + 1));
		end
		return pat;
	endfunction

	function automatic idx_t idx_next(input idx_t idx);
		idx_t nxt;
		nxt = idx + idx_t'(1);
		if (int'(idx) >= NUM_DIGITS - 1) begin
			nxt = '0;
		end
		return nxt;
	endfunction

endpackage

// ===== hw/rtl/dess_in_if.sv =====
// Input channel: received character or scan tick.
interface dess_in_if;
	import dess_pkg::*;

	logic              valid;
	logic              ready;
	logic              mode;
	logic [CHAR_W-1:0] rx_char;

	modport source(output valid, mode, rx_char, input ready);
	modport sink(input valid, mode, rx_char, output ready);
endinterface

// ===== hw/rtl/dess_out_if.sv =====
// Output channel: held display pattern reported on each scan tick.
interface dess_out_if;
	import dess_pkg::*;

	logic             valid;
	logic             ready;
	logic [SEG_W-1:0] segment_pattern;
	logic [SEG_W-1:0] digit_select;
	logic             updated;

	modport source(output valid, segment_pattern, digit_select, updated, input ready);
	modport sink(input valid, segment_pattern, digit_select, updated, output ready);
endinterface

// ===== hw/rtl/dess_digit_buf.sv =====
// Digit slot buffer with filled marks and group entry counter.
`include "digit_entry_seven_segment_scanner_core_macros.svh"

module dess_digit_buf (
	input  logic                clk,
	input  logic                arst_n,
	input  dess_pkg::dess_push_t push,
	output dess_pkg::dess_buf_t  view
);
	import dess_pkg::*;

	logic [NUM_DIGITS-1:0][DIGIT_W-1:0] slots_q;
	logic [NUM_DIGITS-1:0]              filled_q;
	idx_t                               count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slots_q  <= '0;
			filled_q <= '0;
			count_q  <= '0;
		end else if (push.shift) begin
			if (count_q == '0) begin
				slots_q     <= '0;
				filled_q    <= '0;
				slots_q[0]  <= push.digit;
				filled_q[0] <= 1'b1;
			end else begin
				for (int k = NUM_DIGITS - 1; k > 0; k--) begin
					slots_q[k]  <= slots_q[k-1];
					filled_q[k] <= filled_q[k-1];
				end
				slots_q[0]  <= push.digit;
				filled_q[0] <= 1'b1;
			end
			count_q <= idx_next(count_q);
		end
	end

	assign view.slots  = slots_q;
	assign view.filled = filled_q;

	`DESS_ASSERT_ALWAYS(a_count_range, (int'(count_q) < NUM_DIGITS), "entry count out of range")
	`DESS_ASSERT(a_group_clear, (push.shift && count_q == '0) |=> (filled_q == NUM_DIGITS'(1)), "group start did not blank buffer")
endmodule

// ===== hw/rtl/dess_scan.sv =====
// Scan index, held display registers and result register.
`include "digit_entry_seven_segment_scanner_core_macros.svh"

module dess_scan (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               tick,
	input  dess_pkg::dess_buf_t view,
	output logic               free,
	dess_out_if.source         res
);
	import dess_pkg::*;

	idx_t             scan_q;
	logic [SEG_W-1:0] held_seg_q;
	logic [SEG_W-1:0] held_sel_q;
	logic             res_valid_q;
	logic [SEG_W-1:0] res_seg_q;
	logic [SEG_W-1:0] res_sel_q;
	logic             res_upd_q;

	logic             hit;
	logic [SEG_W-1:0] seg_new;
	logic [SEG_W-1:0] sel_new;

	always_comb begin
		hit     = view.filled[scan_q];
		seg_new = held_seg_q;
		sel_new = held_sel_q;
		if (hit) begin
			seg_new = SEG_LUT[view.slots[scan_q]];
			sel_new = select_for(scan_q);
		end
	end

	assign free = !res_valid_q || res.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_q      <= '0;
			held_seg_q  <= '0;
			held_sel_q  <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (tick) begin
				scan_q      <= idx_next(scan_q);
				held_seg_q  <= seg_new;
				held_sel_q  <= sel_new;
				res_valid_q <= 1'b1;
			end else if (res.ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (tick) begin
			res_seg_q <= seg_new;
			res_sel_q <= sel_new;
			res_upd_q <= hit;
		end
	end

	assign res.valid           = res_valid_q;
	assign res.segment_pattern = res_seg_q;
	assign res.digit_select    = res_sel_q;
	assign res.updated         = res_upd_q;

	`DESS_ASSERT_ALWAYS(a_scan_range, (int'(scan_q) < NUM_DIGITS), "scan index out of range")
	`DESS_ASSERT(a_upd_nonzero, (res_valid_q && res_upd_q) |-> (res_seg_q != '0 && res_sel_q != '0), "updated result carries empty pattern")
endmodule

// ===== hw/rtl/digit_entry_seven_segment_scanner_core.sv =====
// Top level: input stage register feeding the digit buffer and the scan unit.
//
//  channel | dir | payload                                   | transfer
//  cmd     | in  | mode, rx_char                             | valid && ready
//  res     | out | segment_pattern, digit_select, updated    | valid && ready
//
// One item per cycle sustained unless a stalled result holds a scan tick; each item
// passes the input stage register before it reaches the state. A tick's result is valid
// right after the edge the tick leaves the input stage, held in the result register.
// Reset clears the slots, filled marks, counters and held registers.
// A stalled result holds a scan tick in the input stage and every item behind it.
// cmd.ready depends combinationally on res.ready through the input stage.

module digit_entry_seven_segment_scanner_core (
	input  logic       clk,
	input  logic       arst_n,
	dess_in_if.sink    cmd,
	dess_out_if.source res
);
	import dess_pkg::*;

	logic              valid_s1;
	logic              mode_s1;
	logic [CHAR_W-1:0] char_s1;

	logic       free;
	logic       adv;
	logic       is_digit;
	dess_push_t push;
	dess_buf_t  view;

	assign adv       = valid_s1 && (!mode_s1 || free);
	assign cmd.ready = !valid_s1 || adv;

	always_comb begin
		is_digit   = char_s1 inside {[CHAR_ZERO:CHAR_NINE]};
		push.shift = adv && !mode_s1 && is_digit;
		push.digit = DIGIT_W'(char_s1 - CHAR_ZERO);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (cmd.ready) begin
			valid_s1 <= cmd.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.ready && cmd.valid) begin
			mode_s1 <= cmd.mode;
			char_s1 <= cmd.rx_char;
		end
	end

	dess_digit_buf u_buf (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (push),
		.view  (view)
	);

	dess_scan u_scan (
		.clk   (clk),
		.arst_n(arst_n),
		.tick  (adv && mode_s1),
		.view  (view),
		.free  (free),
		.res   (res)
	);
endmodule
